// ===== design/gcpg_pkg.sv =====
package gcpg_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int SCREEN_BITS   = 12;
    localparam int CELL_BITS     = 8;
    localparam int COLOR_BITS    = 24;
    localparam int CHAN_BITS     = 8;
    localparam int WSEL_BITS     = 4;
    localparam int CHAN_SEL_BITS = 3 * WSEL_BITS;

    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;
    typedef logic [CELL_BITS-1:0]     t_cell;
    typedef logic [COLOR_BITS-1:0]    t_color;
    typedef logic [CHAN_BITS-1:0]     t_chan;
    typedef logic [WSEL_BITS-1:0]     t_wsel;

    localparam t_cfg_idx CFG_SCREEN_WIDTH   = 3'd0;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT  = 3'd1;
    localparam t_cfg_idx CFG_CELLS_PER_SIDE = 3'd2;
    localparam t_cfg_idx CFG_FIRST_COLOR    = 3'd3;
    localparam t_cfg_idx CFG_COLOR_STEP     = 3'd4;
    localparam t_cfg_idx CFG_INDEXED_MODE   = 3'd5;
    localparam t_cfg_idx CFG_CHANNEL_WIDTHS = 3'd6;

    localparam int                     RST_SCREEN_WIDTH   = 1024;
    localparam int                     RST_SCREEN_HEIGHT  = 768;
    localparam t_cell                  RST_CELLS_PER_SIDE = 8'd1;
    localparam t_color                 RST_FIRST_COLOR    = 24'd0;
    localparam t_chan                  RST_COLOR_STEP     = 8'd1;
    localparam logic                   RST_INDEXED_MODE   = 1'b1;
    localparam logic [CHAN_SEL_BITS-1:0] RST_CHANNEL_WIDTHS = 12'h565;

endpackage

// ===== design/gcpg_ifs.sv =====
interface gcpg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface gcpg_res_if #(
    parameter int COORD_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic                   painted;
    gcpg_pkg::t_color       pixel_color;
    logic                   frame_end;

    modport source (output valid, output pixel_x, output pixel_y, output painted,
                    output pixel_color, output frame_end, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input painted,
                    input pixel_color, input frame_end, output ready);
endinterface

interface gcpg_cfg_if;
    logic                valid;
    logic                ready;
    gcpg_pkg::t_cfg_idx  idx;
    gcpg_pkg::t_cfg_data data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

// ===== design/grid_color_pattern_generator.sv =====
// one request at a time; a plain advance steps through S_MUL0, S_MUL1 and S_DONE and
// registers its result on leaving S_DONE, and only then can the next request be taken
// a frame start (restart, or advancing past the last pixel) first runs S_DIV for the
// cell width and then the height, one quotient bit per cycle in a shared divider
// colour takes two passes through one 8x8 multiplier; a stalled result holds the next back
// synchronous active-low reset: registers to defaults, position and cell sizes zero
module grid_color_pattern_generator #(
    parameter int COORD_BITS = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gcpg_req_if.sink      i_req,
    gcpg_cfg_if.sink      i_cfg,
    gcpg_res_if.source    o_res
);

    localparam int CNT_BITS = $clog2(COORD_BITS);
    localparam int CELL_BITS_P1 = gcpg_pkg::CELL_BITS;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS:0]   t_coord_ext;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL0 = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // configuration
    t_coord                r_scr_w;
    t_coord                r_scr_h;
    gcpg_pkg::t_cell       r_cells;
    gcpg_pkg::t_color      r_first;
    gcpg_pkg::t_chan       r_step;
    logic                  r_indexed;
    logic [gcpg_pkg::CHAN_SEL_BITS-1:0] r_chan_w;

    // raster state
    logic [2:0]            r_state;
    t_coord                r_x, r_y, r_xc, r_yc, r_cw, r_ch;
    gcpg_pkg::t_cell       r_col, r_row;
    t_coord                n_x, n_y, n_xc, n_yc;
    gcpg_pkg::t_cell       n_col, n_row;
    logic                  n_start;

    // divider
    t_coord                r_quot;
    gcpg_pkg::t_cell       r_rem;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_phase;
    logic [CELL_BITS_P1:0] div_trial;

    // multiplier and output
    gcpg_pkg::t_chan       r_p0, r_p1;
    logic                  r_ovalid;
    t_coord                r_px, r_py;
    logic                  r_painted, r_fend;
    gcpg_pkg::t_color      r_color;

    t_coord                eff_w, eff_h;
    gcpg_pkg::t_cell       eff_n;
    t_coord_ext            x_inc, y_inc, xc_inc, yc_inc;
    logic                  x_more, y_more;
    logic                  div_ge;
    logic [CELL_BITS_P1:0] div_diff;
    gcpg_pkg::t_cell       div_rem_n;
    t_coord                div_q;
    gcpg_pkg::t_chan       mul_a, mul_b;
    logic [2*gcpg_pkg::CHAN_BITS-1:0] mul_full;
    logic                  painted;
    gcpg_pkg::t_wsel       wr, wg, wb;
    gcpg_pkg::t_chan       mr, mg, mb;
    gcpg_pkg::t_chan       r0, g0, b0, ch_r, ch_g, ch_b;
    gcpg_pkg::t_chan       idx_sum;
    gcpg_pkg::t_color      idx_color, dir_color, pix_color;
    logic                  cfg_we;
    logic                  out_load;

    function automatic gcpg_pkg::t_wsel clamp_w(input gcpg_pkg::t_wsel w);
        gcpg_pkg::t_wsel res;
        res = w;
        if (w == '0) begin
            res = gcpg_pkg::t_wsel'(1);
        end else if (w > gcpg_pkg::t_wsel'(gcpg_pkg::CHAN_BITS)) begin
            res = gcpg_pkg::t_wsel'(gcpg_pkg::CHAN_BITS);
        end
        return res;
    endfunction

    function automatic gcpg_pkg::t_chan low_mask(input gcpg_pkg::t_wsel w);
        logic [gcpg_pkg::CHAN_BITS:0] m;
        m = ({{gcpg_pkg::CHAN_BITS{1'b0}}, 1'b1} << w) - {{gcpg_pkg::CHAN_BITS{1'b0}}, 1'b1};
        return m[gcpg_pkg::CHAN_BITS-1:0];
    endfunction

    // configuration port
    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w   <= COORD_BITS'(gcpg_pkg::RST_SCREEN_WIDTH);
            r_scr_h   <= COORD_BITS'(gcpg_pkg::RST_SCREEN_HEIGHT);
            r_cells   <= gcpg_pkg::RST_CELLS_PER_SIDE;
            r_first   <= gcpg_pkg::RST_FIRST_COLOR;
            r_step    <= gcpg_pkg::RST_COLOR_STEP;
            r_indexed <= gcpg_pkg::RST_INDEXED_MODE;
            r_chan_w  <= gcpg_pkg::RST_CHANNEL_WIDTHS;
        end else if (cfg_we) begin
            unique case (i_cfg.idx)
                gcpg_pkg::CFG_SCREEN_WIDTH: begin
                    r_scr_w <= COORD_BITS'(i_cfg.data[gcpg_pkg::SCREEN_BITS-1:0]);
                end
                gcpg_pkg::CFG_SCREEN_HEIGHT: begin
                    r_scr_h <= COORD_BITS'(i_cfg.data[gcpg_pkg::SCREEN_BITS-1:0]);
                end
                gcpg_pkg::CFG_CELLS_PER_SIDE: begin
                    r_cells <= i_cfg.data[gcpg_pkg::CELL_BITS-1:0];
                end
                gcpg_pkg::CFG_FIRST_COLOR: begin
                    r_first <= i_cfg.data[gcpg_pkg::COLOR_BITS-1:0];
                end
                gcpg_pkg::CFG_COLOR_STEP: begin
                    r_step <= i_cfg.data[gcpg_pkg::CHAN_BITS-1:0];
                end
                gcpg_pkg::CFG_INDEXED_MODE: begin
                    r_indexed <= i_cfg.data[0];
                end
                gcpg_pkg::CFG_CHANNEL_WIDTHS: begin
                    r_chan_w <= i_cfg.data[gcpg_pkg::CHAN_SEL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign eff_w = (r_scr_w == '0) ? t_coord'(1) : r_scr_w;
    assign eff_h = (r_scr_h == '0) ? t_coord'(1) : r_scr_h;
    assign eff_n = (r_cells == '0) ? gcpg_pkg::t_cell'(1) : r_cells;

    assign x_inc  = {1'b0, r_x} + t_coord_ext'(1);
    assign y_inc  = {1'b0, r_y} + t_coord_ext'(1);
    assign xc_inc = {1'b0, r_xc} + t_coord_ext'(1);
    assign yc_inc = {1'b0, r_yc} + t_coord_ext'(1);
    assign x_more = x_inc < {1'b0, eff_w};
    assign y_more = y_inc < {1'b0, eff_h};

    // next raster position
    always_comb begin
        n_x     = r_x;
        n_y     = r_y;
        n_xc    = r_xc;
        n_yc    = r_yc;
        n_col   = r_col;
        n_row   = r_row;
        n_start = 1'b0;
        if (i_req.restart) begin
            n_start = 1'b1;
        end else if (x_more) begin
            n_x = x_inc[COORD_BITS-1:0];
            if (r_cw != '0 && r_col < eff_n) begin
                if (xc_inc >= {1'b0, r_cw}) begin
                    n_xc  = '0;
                    n_col = r_col + gcpg_pkg::t_cell'(1);
                end else begin
                    n_xc = xc_inc[COORD_BITS-1:0];
                end
            end
        end else if (y_more) begin
            n_y   = y_inc[COORD_BITS-1:0];
            n_x   = '0;
            n_xc  = '0;
            n_col = '0;
            if (r_ch != '0 && r_row < eff_n) begin
                if (yc_inc >= {1'b0, r_ch}) begin
                    n_yc  = '0;
                    n_row = r_row + gcpg_pkg::t_cell'(1);
                end else begin
                    n_yc = yc_inc[COORD_BITS-1:0];
                end
            end
        end else begin
            n_start = 1'b1;
        end
        if (n_start) begin
            n_x   = '0;
            n_y   = '0;
            n_xc  = '0;
            n_yc  = '0;
            n_col = '0;
            n_row = '0;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign div_trial = {r_rem, r_quot[COORD_BITS-1]};
    assign div_ge    = div_trial >= {1'b0, eff_n};
    assign div_diff  = div_trial - {1'b0, eff_n};
    assign div_rem_n = div_ge ? div_diff[CELL_BITS_P1-1:0] : div_trial[CELL_BITS_P1-1:0];
    assign div_q     = {r_quot[COORD_BITS-2:0], div_ge};

    // shared multiplier, only the low byte is ever used
    always_comb begin
        if (r_state == S_MUL0) begin
            mul_a = r_indexed ? r_row : r_col;
            mul_b = r_indexed ? eff_n : r_step;
        end else begin
            mul_a = r_indexed ? (r_p0 + r_col) : r_row;
            mul_b = r_step;
        end
    end
    assign mul_full = mul_a * mul_b;

    // colour assembly
    assign painted = (r_cw != '0) && (r_ch != '0) && (r_col < eff_n) && (r_row < eff_n);

    assign wr = clamp_w(r_chan_w[3*gcpg_pkg::WSEL_BITS-1:2*gcpg_pkg::WSEL_BITS]);
    assign wg = clamp_w(r_chan_w[2*gcpg_pkg::WSEL_BITS-1:gcpg_pkg::WSEL_BITS]);
    assign wb = clamp_w(r_chan_w[gcpg_pkg::WSEL_BITS-1:0]);
    assign mr = low_mask(wr);
    assign mg = low_mask(wg);
    assign mb = low_mask(wb);

    assign b0   = r_first[gcpg_pkg::CHAN_BITS-1:0] & mb;
    assign g0   = gcpg_pkg::t_chan'(r_first >> wb) & mg;
    assign r0   = gcpg_pkg::t_chan'(r_first >> ({1'b0, wb} + {1'b0, wg})) & mr;
    assign ch_r = (r0 + r_p0) & mr;
    assign ch_g = (g0 + r_p1) & mg;
    assign ch_b = (b0 + r_p0 + r_p1) & mb;

    assign idx_sum   = r_first[gcpg_pkg::CHAN_BITS-1:0] + r_p1;
    assign idx_color = gcpg_pkg::t_color'(idx_sum);
    assign dir_color = (gcpg_pkg::t_color'(ch_r) << ({1'b0, wg} + {1'b0, wb}))
                     | (gcpg_pkg::t_color'(ch_g) << wb)
                     | gcpg_pkg::t_color'(ch_b);
    assign pix_color = !painted ? '0 : (r_indexed ? idx_color : dir_color);

    assign out_load = (r_state == S_DONE) && (!r_ovalid || o_res.ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_x      <= '0;
            r_y      <= '0;
            r_xc     <= '0;
            r_yc     <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_cw     <= '0;
            r_ch     <= '0;
            r_cnt    <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_x   <= n_x;
                        r_y   <= n_y;
                        r_xc  <= n_xc;
                        r_yc  <= n_yc;
                        r_col <= n_col;
                        r_row <= n_row;
                        if (n_start) begin
                            r_cnt   <= '0;
                            r_phase <= 1'b0;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_BITS'(COORD_BITS - 1)) begin
                        r_cnt <= '0;
                        if (!r_phase) begin
                            r_cw    <= div_q;
                            r_phase <= 1'b1;
                        end else begin
                            r_ch    <= div_q;
                            r_state <= S_MUL0;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_BITS'(1);
                    end
                end
                S_MUL0: begin
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req.valid && n_start) begin
            r_quot <= eff_w;
            r_rem  <= '0;
        end else if (r_state == S_DIV) begin
            if (r_cnt == CNT_BITS'(COORD_BITS - 1)) begin
                r_quot <= eff_h;
                r_rem  <= '0;
            end else begin
                r_quot <= div_q;
                r_rem  <= div_rem_n;
            end
        end
        if (r_state == S_MUL0) begin
            r_p0 <= mul_full[gcpg_pkg::CHAN_BITS-1:0];
        end
        if (r_state == S_MUL1) begin
            r_p1 <= mul_full[gcpg_pkg::CHAN_BITS-1:0];
        end
        if (out_load) begin
            r_px      <= r_x;
            r_py      <= r_y;
            r_painted <= painted;
            r_color   <= pix_color;
            r_fend    <= !x_more && !y_more;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_ovalid;
    assign o_res.pixel_x     = r_px;
    assign o_res.pixel_y     = r_py;
    assign o_res.painted     = r_painted;
    assign o_res.pixel_color = r_color;
    assign o_res.frame_end   = r_fend;

endmodule

// ===== design/gcpg_checker.sv =====
module gcpg_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] i_pixel_x,
    input logic                  i_painted,
    input gcpg_pkg::t_color      i_pixel_color
);

    // a held result keeps its x coordinate and colour
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_pixel_x) && $stable(i_pixel_color))
        else $error("result changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // unpainted pixels carry no colour
    a_unpainted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_painted |-> i_pixel_color == '0)
        else $error("colour on unpainted pixel");

    // reset empties the output and leaves the block ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");

endmodule

bind grid_color_pattern_generator gcpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_gcpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_pixel_x     (o_res.pixel_x),
    .i_painted     (o_res.painted),
    .i_pixel_color (o_res.pixel_color)
);

// ===== test/gcpg_pixel_check.sv =====
`timescale 1ns / 1ps

module gcpg_pixel_check (
    input  logic i_clk,
    input  logic i_rst_n,
    gcpg_req_if  i_req,
    gcpg_cfg_if  i_cfg,
    gcpg_res_if  i_res,
    output int   o_errors,
    output int   o_waiting
);

    typedef logic [gcpg_pkg::SCREEN_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord           x;
        t_coord           y;
        logic             painted;
        gcpg_pkg::t_color color;
        logic             frame_end;
    } t_pixel;

    // register copies
    t_coord                             scr_w;
    t_coord                             scr_h;
    gcpg_pkg::t_cell                    n_cells;
    gcpg_pkg::t_color                   first_col;
    gcpg_pkg::t_chan                    step_col;
    logic                               idx_mode;
    logic [gcpg_pkg::CHAN_SEL_BITS-1:0] chan_widths;

    // raster position
    t_coord          x_pos;
    t_coord          y_pos;
    t_coord          x_in;
    t_coord          y_in;
    t_coord          cell_w;
    t_coord          cell_h;
    gcpg_pkg::t_cell col;
    gcpg_pkg::t_cell row;

    t_pixel expected_pixels[$];

    function automatic int unsigned at_least_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic int unsigned chan_width(input int unsigned shift);
        int unsigned w;
        w = (chan_widths >> shift) & 4'hF;
        if (w < 1) w = 1;
        if (w > 8) w = 8;
        return w;
    endfunction

    function automatic void start_frame();
        x_pos  = '0;
        y_pos  = '0;
        x_in   = '0;
        y_in   = '0;
        col    = '0;
        row    = '0;
        cell_w = t_coord'(at_least_one(scr_w) / at_least_one(n_cells));
        cell_h = t_coord'(at_least_one(scr_h) / at_least_one(n_cells));
    endfunction

    function automatic void advance_pixel();
        int unsigned n;
        n = at_least_one(n_cells);
        if (x_pos + 1 < at_least_one(scr_w)) begin
            x_pos = x_pos + 1'b1;
            if (cell_w != 0 && col < n) begin
                x_in = x_in + 1'b1;
                if (x_in >= cell_w) begin
                    x_in = '0;
                    col  = col + 1'b1;
                end
            end
        end else if (y_pos + 1 < at_least_one(scr_h)) begin
            y_pos = y_pos + 1'b1;
            x_pos = '0;
            x_in  = '0;
            col   = '0;
            if (cell_h != 0 && row < n) begin
                y_in = y_in + 1'b1;
                if (y_in >= cell_h) begin
                    y_in = '0;
                    row  = row + 1'b1;
                end
            end
        end else begin
            start_frame();
        end
    endfunction

    function automatic gcpg_pkg::t_color cell_color(input int unsigned c, input int unsigned r);
        int unsigned rw, gw, bw, r0, g0, b0, rc, gc, bc, k;
        if (idx_mode) begin
            k = r * at_least_one(n_cells) + c;
            return gcpg_pkg::t_color'((first_col + k * step_col) & 8'hFF);
        end
        rw = chan_width(8);
        gw = chan_width(4);
        bw = chan_width(0);
        b0 = first_col & ((1 << bw) - 1);
        g0 = (first_col >> bw) & ((1 << gw) - 1);
        r0 = (first_col >> (bw + gw)) & ((1 << rw) - 1);
        rc = (r0 + c * step_col) & ((1 << rw) - 1);
        gc = (g0 + r * step_col) & ((1 << gw) - 1);
        bc = (b0 + (c + r) * step_col) & ((1 << bw) - 1);
        return gcpg_pkg::t_color'((rc << (gw + bw)) | (gc << bw) | bc);
    endfunction

    function automatic t_pixel next_pixel(input logic restart);
        t_pixel      p;
        int unsigned n;
        if (restart) start_frame();
        else advance_pixel();
        n           = at_least_one(n_cells);
        p.x         = x_pos;
        p.y         = y_pos;
        p.painted   = cell_w != 0 && cell_h != 0 && col < n && row < n;
        p.color     = p.painted ? cell_color(int'(col), int'(row)) : '0;
        p.frame_end = (x_pos + 1 >= at_least_one(scr_w)) && (y_pos + 1 >= at_least_one(scr_h));
        return p;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            scr_w       = t_coord'(gcpg_pkg::RST_SCREEN_WIDTH);
            scr_h       = t_coord'(gcpg_pkg::RST_SCREEN_HEIGHT);
            n_cells     = gcpg_pkg::RST_CELLS_PER_SIDE;
            first_col   = gcpg_pkg::RST_FIRST_COLOR;
            step_col    = gcpg_pkg::RST_COLOR_STEP;
            idx_mode    = gcpg_pkg::RST_INDEXED_MODE;
            chan_widths = gcpg_pkg::RST_CHANNEL_WIDTHS;
            x_pos       = '0;
            y_pos       = '0;
            x_in        = '0;
            y_in        = '0;
            col         = '0;
            row         = '0;
            cell_w      = '0;
            cell_h      = '0;
            o_errors    = 0;
            expected_pixels.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_pixels.size() == 0) begin
                    o_errors++;
                    $display("%0t: pixel result with no request outstanding, got x=%0d y=%0d",
                             $time, i_res.pixel_x, i_res.pixel_y);
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.x, i_res.pixel_x);
                    check_field("pixel_y", want.y, i_res.pixel_y);
                    check_field("painted", want.painted, i_res.painted);
                    check_field("pixel_color", want.color, i_res.pixel_color);
                    check_field("frame_end", want.frame_end, i_res.frame_end);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.idx)
                    gcpg_pkg::CFG_SCREEN_WIDTH:
                        scr_w = i_cfg.data[gcpg_pkg::SCREEN_BITS-1:0];
                    gcpg_pkg::CFG_SCREEN_HEIGHT:
                        scr_h = i_cfg.data[gcpg_pkg::SCREEN_BITS-1:0];
                    gcpg_pkg::CFG_CELLS_PER_SIDE:
                        n_cells = i_cfg.data[gcpg_pkg::CELL_BITS-1:0];
                    gcpg_pkg::CFG_FIRST_COLOR:
                        first_col = i_cfg.data[gcpg_pkg::COLOR_BITS-1:0];
                    gcpg_pkg::CFG_COLOR_STEP:
                        step_col = i_cfg.data[gcpg_pkg::CHAN_BITS-1:0];
                    gcpg_pkg::CFG_INDEXED_MODE:
                        idx_mode = i_cfg.data[0];
                    gcpg_pkg::CFG_CHANNEL_WIDTHS:
                        chan_widths = i_cfg.data[gcpg_pkg::CHAN_SEL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                expected_pixels.push_back(next_pixel(i_req.restart));
            end
        end
        o_waiting = expected_pixels.size();
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam gcpg_pkg::t_cfg_idx CFG_SPARE   = 3'd7;
    localparam int                 PIXEL_COUNT = 1350;
    localparam int                 QUIET_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   n_items;
    int   errors;
    int   waiting;
    int   quiet_cycles;

    gcpg_req_if                     req ();
    gcpg_cfg_if                     cfg ();
    gcpg_res_if #(.COORD_BITS(12))  res ();

    grid_color_pattern_generator #(.COORD_BITS(12)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    gcpg_pixel_check pixel_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_cfg     (cfg),
        .i_res     (res),
        .o_errors  (errors),
        .o_waiting (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input logic restart);
        while (!no_idle && $urandom_range(0, 99) < 30) begin
            req.valid   <= 1'b0;
            req.restart <= ($urandom_range(0, 1) == 1);
            @(negedge i_clk);
        end
        req.valid   <= 1'b1;
        req.restart <= restart;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic write_reg(input gcpg_pkg::t_cfg_idx idx, input gcpg_pkg::t_cfg_data data);
        cfg.valid <= 1'b1;
        cfg.idx   <= idx;
        cfg.data  <= data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender holds off until every pixel has come back
    task automatic settle();
        req.valid <= 1'b0;
        do @(negedge i_clk); while (waiting != 0);
    endtask

    function automatic gcpg_pkg::t_cfg_data dirty(input gcpg_pkg::t_cfg_data v, input int bits);
        if ($urandom_range(0, 3) == 0) return v | (gcpg_pkg::t_cfg_data'($urandom) << bits);
        return v;
    endfunction

    task automatic random_settings();
        gcpg_pkg::t_cfg_data d;
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = gcpg_pkg::t_cfg_data'(4095);
                default: d = gcpg_pkg::t_cfg_data'($urandom_range(1, 24));
            endcase
            write_reg(gcpg_pkg::CFG_SCREEN_WIDTH, dirty(d, gcpg_pkg::SCREEN_BITS));
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = gcpg_pkg::t_cfg_data'(4095);
                default: d = gcpg_pkg::t_cfg_data'($urandom_range(1, 8));
            endcase
            write_reg(gcpg_pkg::CFG_SCREEN_HEIGHT, dirty(d, gcpg_pkg::SCREEN_BITS));
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = gcpg_pkg::t_cfg_data'(255);
                default: d = gcpg_pkg::t_cfg_data'($urandom_range(1, 8));
            endcase
            write_reg(gcpg_pkg::CFG_CELLS_PER_SIDE, dirty(d, gcpg_pkg::CELL_BITS));
        end
        if ($urandom_range(0, 1)) begin
            write_reg(gcpg_pkg::CFG_FIRST_COLOR, gcpg_pkg::t_cfg_data'($urandom));
        end
        if ($urandom_range(0, 1)) begin
            d = gcpg_pkg::t_cfg_data'($urandom_range(0, 255));
            write_reg(gcpg_pkg::CFG_COLOR_STEP, dirty(d, gcpg_pkg::CHAN_BITS));
        end
        if ($urandom_range(0, 1)) begin
            d = gcpg_pkg::t_cfg_data'($urandom_range(0, 1));
            write_reg(gcpg_pkg::CFG_INDEXED_MODE, dirty(d, 1));
        end
        if ($urandom_range(0, 1)) begin
            d = gcpg_pkg::t_cfg_data'($urandom_range(0, 4095));
            write_reg(gcpg_pkg::CFG_CHANNEL_WIDTHS, dirty(d, gcpg_pkg::CHAN_SEL_BITS));
        end
        cfg.valid <= 1'b0;
    endtask

    initial begin
        int burst;
        i_rst_n      = 1'b0;
        no_idle      = 1'b0;
        n_items      = 0;
        req.valid    = 1'b0;
        req.restart  = 1'b0;
        cfg.valid    = 1'b0;
        cfg.idx      = gcpg_pkg::CFG_SCREEN_WIDTH;
        cfg.data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // advance before any frame start, then the reset frame
        send_pixel(1'b0);
        send_pixel(1'b0);
        send_pixel(1'b1);
        send_pixel(1'b0);
        send_pixel(1'b0);

        // zero sizes read as one pixel, one cell
        settle();
        write_reg(gcpg_pkg::CFG_SCREEN_WIDTH, '0);
        write_reg(gcpg_pkg::CFG_SCREEN_HEIGHT, '0);
        write_reg(gcpg_pkg::CFG_CELLS_PER_SIDE, '0);
        write_reg(CFG_SPARE, 24'hFFFFFF);
        cfg.valid <= 1'b0;
        send_pixel(1'b1);
        repeat (2) send_pixel(1'b0);

        // largest screen and grid, direct colour, clamped channel widths
        settle();
        write_reg(gcpg_pkg::CFG_SCREEN_WIDTH, 24'hFFF);
        write_reg(gcpg_pkg::CFG_SCREEN_HEIGHT, 24'hFFF);
        write_reg(gcpg_pkg::CFG_CELLS_PER_SIDE, 24'hFF);
        write_reg(gcpg_pkg::CFG_FIRST_COLOR, 24'hFFFFFF);
        write_reg(gcpg_pkg::CFG_COLOR_STEP, 24'hFF);
        write_reg(gcpg_pkg::CFG_INDEXED_MODE, '0);
        write_reg(gcpg_pkg::CFG_CHANNEL_WIDTHS, 24'h0F0);
        cfg.valid <= 1'b0;
        send_pixel(1'b1);
        repeat (3) send_pixel(1'b0);

        // more cells than pixels, nothing painted, frame wraps
        settle();
        write_reg(gcpg_pkg::CFG_SCREEN_WIDTH, 24'd3);
        write_reg(gcpg_pkg::CFG_SCREEN_HEIGHT, 24'd2);
        write_reg(gcpg_pkg::CFG_CELLS_PER_SIDE, 24'd5);
        write_reg(gcpg_pkg::CFG_INDEXED_MODE, 24'd1);
        write_reg(gcpg_pkg::CFG_FIRST_COLOR, '0);
        write_reg(gcpg_pkg::CFG_COLOR_STEP, '0);
        cfg.valid <= 1'b0;
        send_pixel(1'b1);
        repeat (6) send_pixel(1'b0);

        // small direct colour grid, full width channels
        settle();
        write_reg(gcpg_pkg::CFG_SCREEN_WIDTH, 24'd4);
        write_reg(gcpg_pkg::CFG_CELLS_PER_SIDE, 24'd2);
        write_reg(gcpg_pkg::CFG_INDEXED_MODE, '0);
        write_reg(gcpg_pkg::CFG_CHANNEL_WIDTHS, 24'h888);
        write_reg(gcpg_pkg::CFG_FIRST_COLOR, 24'h123456);
        write_reg(gcpg_pkg::CFG_COLOR_STEP, 24'h81);
        cfg.valid <= 1'b0;
        send_pixel(1'b1);
        repeat (4) send_pixel(1'b0);

        while (n_items < PIXEL_COUNT) begin
            no_idle = (n_items >= 500 && n_items < 750);
            settle();
            random_settings();
            burst = $urandom_range(10, 60);
            send_pixel($urandom_range(0, 1) == 1);
            repeat (burst - 1) send_pixel($urandom_range(0, 19) == 0);
        end
        no_idle = 1'b0;

        settle();
        repeat (40) @(negedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
